FILE: src/brb_pkg.sv
`default_nettype none

package brb_pkg;

    localparam int RING_DEPTH_DEF = 32;
    localparam int MAX_BURST_DEF  = 8;

    localparam int LEN_W     = 4;
    localparam int BYTE_W    = 8;
    localparam int NUM_BYTES = 8;
    localparam int SLOT_W    = 3;
    localparam int STATUS_W  = 2;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 72;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic load_in;
        logic check;
        logic wr_en;
        logic rd_en;
        logic load_out;
    } brb_cmd_t;

    typedef struct packed {
        logic go_write;
        logic go_read;
        logic last;
        logic out_busy;
    } brb_stat_t;

endpackage

`default_nettype wire

FILE: src/brb_ctrl.sv
`default_nettype none

module brb_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire brb_pkg::brb_stat_t stat,
    output brb_pkg::brb_cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WRITE,
        S_READ,
        S_TAIL,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (stat.go_write)
                begin
                    state_next = S_WRITE;
                end
                else if (stat.go_read)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_WRITE:
            begin
                cmd.wr_en = 1'b1;
                if (stat.last)
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                cmd.rd_en = 1'b1;
                if (stat.last)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/brb_datapath.sv
`default_nettype none

module brb_datapath
#(
    parameter int RING_DEPTH = brb_pkg::RING_DEPTH_DEF,
    parameter int MAX_BURST  = brb_pkg::MAX_BURST_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [brb_pkg::IN_TDATA_W-1:0] in_data,
    input  wire logic                           in_func,
    input  wire brb_pkg::brb_cmd_t              cmd,
    output brb_pkg::brb_stat_t                  stat,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [brb_pkg::OUT_TDATA_W-1:0]     out_data,
    output logic [brb_pkg::STATUS_W-1:0]        out_status
);

    localparam int IW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CMPW = IW + brb_pkg::LEN_W;
    localparam int DW   = brb_pkg::NUM_BYTES * brb_pkg::BYTE_W;
    localparam int PADW = brb_pkg::OUT_TDATA_W - DW - brb_pkg::LEN_W;

    localparam logic [IW-1:0]   IDX_LAST = IW'(RING_DEPTH - 1);
    localparam logic [CMPW-1:0] ROOM_MAX = CMPW'(RING_DEPTH - 1);
    localparam logic [CMPW-1:0] BURST_X  = CMPW'(MAX_BURST);

    logic [brb_pkg::BYTE_W-1:0] mem [RING_DEPTH];
    logic [brb_pkg::BYTE_W-1:0] mem_q_reg;

    logic                                                 func_reg;
    logic [brb_pkg::LEN_W-1:0]                            len_reg;
    logic [brb_pkg::NUM_BYTES-1:0][brb_pkg::BYTE_W-1:0]   data_reg;
    logic [IW-1:0]                                        rd_idx_reg;
    logic [IW-1:0]                                        wr_idx_reg;
    logic [IW-1:0]                                        used_reg;
    logic [brb_pkg::LEN_W-1:0]                            n_reg;
    logic [brb_pkg::LEN_W-1:0]                            k_reg;
    logic [brb_pkg::STATUS_W-1:0]                         status_reg;
    logic                                                 cap_pend_reg;
    logic [brb_pkg::SLOT_W-1:0]                           cap_slot_reg;

    logic                                                 out_valid_reg;
    logic [brb_pkg::STATUS_W-1:0]                         out_status_reg;
    logic [brb_pkg::LEN_W-1:0]                            out_cnt_reg;
    logic [DW-1:0]                                        out_bytes_reg;

    logic [CMPW-1:0]              len_x;
    logic [CMPW-1:0]              used_x;
    logic [CMPW-1:0]              lim_x;
    logic                         wr_reject;
    logic                         rd_empty;
    logic [brb_pkg::LEN_W-1:0]    n_calc;
    logic [brb_pkg::STATUS_W-1:0] status_calc;
    logic [IW-1:0]                wr_idx_inc;
    logic [IW-1:0]                rd_idx_inc;

    always_comb
    begin
        len_x     = CMPW'(len_reg);
        used_x    = CMPW'(used_reg);
        lim_x     = (len_x > BURST_X) ? BURST_X : len_x;
        wr_reject = (len_x > BURST_X) || (len_x > (ROOM_MAX - used_x));
        rd_empty  = (used_reg == '0);
        if (func_reg == brb_pkg::OP_WRITE)
        begin
            status_calc = wr_reject ? brb_pkg::ST_FULL : brb_pkg::ST_OK;
            n_calc      = wr_reject ? '0 : len_reg;
        end
        else
        begin
            status_calc = rd_empty ? brb_pkg::ST_EMPTY : brb_pkg::ST_OK;
            if (rd_empty)
            begin
                n_calc = '0;
            end
            else if (lim_x > used_x)
            begin
                n_calc = brb_pkg::LEN_W'(used_reg);
            end
            else
            begin
                n_calc = lim_x[brb_pkg::LEN_W-1:0];
            end
        end
        wr_idx_inc = (wr_idx_reg == IDX_LAST) ? '0 : wr_idx_reg + 1'b1;
        rd_idx_inc = (rd_idx_reg == IDX_LAST) ? '0 : rd_idx_reg + 1'b1;
    end

    assign stat.go_write = (func_reg == brb_pkg::OP_WRITE) && (n_calc != '0);
    assign stat.go_read  = (func_reg == brb_pkg::OP_READ) && (n_calc != '0);
    assign stat.last     = (k_reg == n_reg - 1'b1);
    assign stat.out_busy = out_valid_reg && !out_ready;

    // single-port byte store, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_idx_reg] <= data_reg[k_reg[brb_pkg::SLOT_W-1:0]];
        end
        else if (cmd.rd_en)
        begin
            mem_q_reg <= mem[rd_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg <= in_func;
            len_reg  <= in_data[brb_pkg::LEN_W-1:0];
            data_reg <= in_data[brb_pkg::LEN_W +: DW];
        end
        else if (cmd.check && (func_reg == brb_pkg::OP_READ))
        begin
            data_reg <= '0;
        end
        else if (cap_pend_reg)
        begin
            data_reg[cap_slot_reg] <= mem_q_reg;
        end
        if (cmd.check)
        begin
            status_reg <= status_calc;
            n_reg      <= n_calc;
        end
        if (cmd.rd_en)
        begin
            cap_slot_reg <= k_reg[brb_pkg::SLOT_W-1:0];
        end
        if (cmd.load_out)
        begin
            out_status_reg <= status_reg;
            out_cnt_reg    <= (func_reg == brb_pkg::OP_READ) ? n_reg : '0;
            out_bytes_reg  <= (func_reg == brb_pkg::OP_READ) ? data_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            used_reg      <= '0;
            k_reg         <= '0;
            cap_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_pend_reg <= cmd.rd_en;
            if (cmd.check)
            begin
                k_reg <= '0;
            end
            else if (cmd.wr_en || cmd.rd_en)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (cmd.wr_en)
            begin
                wr_idx_reg <= wr_idx_inc;
                used_reg   <= used_reg + 1'b1;
            end
            else if (cmd.rd_en)
            begin
                rd_idx_reg <= rd_idx_inc;
                used_reg   <= used_reg - 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_data   = {{PADW{1'b0}}, out_bytes_reg, out_cnt_reg};

endmodule

`default_nettype wire

FILE: src/byte_ring_buffer_burst_unit.sv
// Channel   Dir  tdata (low bit up)                            tuser
// s_axis    in   burst_length[3:0], write_byte_0..7, pad to 72  func
// m_axis    out  byte_count[3:0], read_byte_0..7, pad to 72     status
//
// One transaction at a time, in order: accept, check, write or read of the bytes (a read
// also passes a tail state), hand-over; rejected writes and empty reads skip the bytes.
// The single-port byte store moves one byte per cycle.
// rst_n clears indices, fill level and handshake state; store contents are not cleared.
// A stalled m_axis result holds; the unit takes the next transaction meanwhile
// and waits before its own result only while the output is still occupied.
`default_nettype none

module byte_ring_buffer_burst_unit
#(
    parameter int RING_DEPTH = brb_pkg::RING_DEPTH_DEF,
    parameter int MAX_BURST  = brb_pkg::MAX_BURST_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [brb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // burst_length, write_byte_0..7
    input  wire logic                            s_axis_tuser,  // func
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [brb_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // byte_count, read_byte_0..7
    output logic [brb_pkg::STATUS_W-1:0]         m_axis_tuser   // status
);

    brb_pkg::brb_cmd_t  cmd;
    brb_pkg::brb_stat_t stat;

    brb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    brb_datapath
    #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_BURST  (MAX_BURST)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_data    (s_axis_tdata),
        .in_func    (s_axis_tuser),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_status (m_axis_tuser)
    );

endmodule

`default_nettype wire

FILE: src/brb_checker.sv
`default_nettype none

module brb_checker
(
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic [brb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [brb_pkg::STATUS_W-1:0]    m_axis_tuser,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a transaction is in progress");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == brb_pkg::ST_FULL ||
                          m_axis_tuser == brb_pkg::ST_EMPTY)
            |-> m_axis_tdata == '0)
        else $error("failed transaction carries data");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd8 && m_axis_tuser <= brb_pkg::ST_EMPTY)
        else $error("result count or status out of range");

endmodule

bind byte_ring_buffer_burst_unit brb_checker u_brb_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire
